// ----- rtl/cbgs_pkg.sv -----
package cbgs_pkg;

    localparam int TB_W   = 17;
    localparam int RATE_W = 11;
    localparam int A_W    = TB_W + 3;
    localparam int C_W    = 8;
    localparam int M_W    = 4;
    localparam int IDX_W  = 3;
    localparam int SZ_W   = TB_W + 1;
    localparam int PROD_W = C_W + TB_W;

    // serial divider geometry
    localparam int DIVD_W = A_W;
    localparam int DIVR_W = 14;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [TB_W-1:0]   MAX_TB_BYTES = TB_W'(65536);
    localparam logic [M_W-1:0]    MAX_GROUPS   = M_W'(8);

    localparam logic [DIVR_W-1:0] KCB_SMALL = DIVR_W'(3840);
    localparam logic [DIVR_W-1:0] KCB_LARGE = DIVR_W'(8448);

    localparam logic [A_W-1:0]    A_SMALL_LIMIT = A_W'(292);
    localparam logic [A_W-1:0]    A_MID_LIMIT   = A_W'(3824);
    localparam logic [RATE_W-1:0] RATE_MID      = RATE_W'(686);
    localparam logic [RATE_W-1:0] RATE_LOW      = RATE_W'(256);

    localparam logic [STEP_W-1:0] STEPS_C = STEP_W'(DIVD_W);
    localparam logic [STEP_W-1:0] STEPS_S = STEP_W'(TB_W);
    localparam logic [STEP_W-1:0] STEPS_M = STEP_W'(C_W);

    // register indexes
    localparam logic REG_CBG_ENABLE = 1'b0;
    localparam logic REG_MAX_GROUPS = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic           enable;
        logic [M_W-1:0] max_groups;
    } cfg_t;

endpackage

// ----- rtl/cbgs_cfg.sv -----
module cbgs_cfg
    import cbgs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [M_W-1:0] cfg_data,
    output cfg_t           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CBG_ENABLE:
                begin
                    cfg_next.enable = cfg_data[0];
                end
                REG_MAX_GROUPS:
                begin
                    // drop group counts the block does not support
                    if ((cfg_data inside {M_W'(2), M_W'(4), M_W'(6), M_W'(8)}) &&
                        (cfg_data <= MAX_GROUPS))
                    begin
                        cfg_next.max_groups = cfg_data;
                    end
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.max_groups <= MAX_GROUPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/cbgs_div.sv -----
module cbgs_div
    import cbgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient,
    output logic [DIVR_W-1:0] remainder
);

    // Restoring divider, one quotient bit per cycle. The dividend is loaded
    // left-aligned, so after ctl.steps shifts the quotient sits in the low bits.
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            rem_next = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/code_block_group_segmenter.sv -----
// Flow: with groups enabled, an input beat goes through serial divides of 20, 17 and 8 bits,
// then a multiply, before the first group beat is offered; with groups disabled, through the
// 17- and 8-bit divides and the multiply; a zero size goes straight to its group beat. Groups
// then follow one per cycle while the output is taken. A new block is taken only when idle,
// after the last group of the one before has been placed on the output, so stalls hold it back.
// Reset (rst_n, asynchronous, active low): idle, output dropped, cbg_enable 0, max_groups 8.
module code_block_group_segmenter
    import cbgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tb_bytes [16:0], code_rate_x1024 [27:17], zero fill [31:28]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // group_index [2:0], group_bytes [19:3], group_count [23:20], block_count [31:24]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // length_error [0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [M_W-1:0]        cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV_C = 6'b000010,
        S_DIV_S = 6'b000100,
        S_DIV_M = 6'b001000,
        S_MUL   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [TB_W-1:0]  rem_bytes_reg, rem_bytes_next;
    logic [TB_W-1:0]  bytes_reg, bytes_next;
    logic [C_W-1:0]   c_reg, c_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [TB_W-1:0]  cb_reg, cb_next;
    logic [C_W-1:0]   per_lo_reg, per_lo_next;
    logic [C_W-1:0]   per_hi_reg, per_hi_next;
    logic [M_W-1:0]   mid_reg, mid_next;
    logic [SZ_W-1:0]  sz_lo_reg, sz_lo_next;
    logic [SZ_W-1:0]  sz_hi_reg, sz_hi_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    cfg_t              cfg;
    div_ctl_t          div_ctl;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVR_W-1:0] div_rem;

    logic [TB_W-1:0]   bytes_in;
    logic [RATE_W-1:0] rate_in;
    logic [TB_W-1:0]   bytes_cl;
    logic [A_W-1:0]    a_val;
    logic              kcb_small;
    logic [DIVR_W-1:0] kcb;
    logic              accept;
    logic [C_W-1:0]    c_new;
    logic [TB_W-1:0]   cb_dvd;
    logic [PROD_W-1:0] prod_lo;
    logic [PROD_W-1:0] prod_hi;
    logic [SZ_W-1:0]   share;
    logic [TB_W-1:0]   grp;
    logic              grp_last;
    logic              out_free;

    cbgs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbgs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign bytes_in  = s_tdata[TB_W-1:0];
    assign rate_in   = s_tdata[TB_W +: RATE_W];
    assign bytes_cl  = (bytes_in > MAX_TB_BYTES) ? MAX_TB_BYTES : bytes_in;
    assign a_val     = {bytes_cl, 3'b000};
    assign kcb_small = (a_val < A_SMALL_LIMIT) ||
                       ((a_val <= A_MID_LIMIT) && (rate_in <= RATE_MID)) ||
                       (rate_in <= RATE_LOW);
    assign kcb       = kcb_small ? KCB_SMALL : KCB_LARGE;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign c_new     = div_quo[C_W-1:0];
    assign cb_dvd    = bytes_reg + TB_W'(c_new) - TB_W'(1);

    assign prod_lo   = per_lo_reg * cb_reg;
    assign prod_hi   = per_hi_reg * cb_reg;

    // cap each share by what is left of the block
    assign share     = (M_W'(idx_reg) < mid_reg) ? sz_hi_reg : sz_lo_reg;
    assign grp       = ({1'b0, rem_bytes_reg} >= share) ? share[TB_W-1:0] : rem_bytes_reg;
    assign grp_last  = ((M_W'(idx_reg) + M_W'(1)) == m_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // divider launches
    always_comb
    begin
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (bytes_in != '0))
                begin
                    div_ctl.start = 1'b1;
                    if (cfg.enable)
                    begin
                        div_ctl.steps = STEPS_C;
                        div_dividend  = a_val + A_W'(kcb) - A_W'(1);
                        div_divisor   = kcb;
                    end
                    else
                    begin
                        // one block: the block size is the byte count itself
                        div_ctl.steps = STEPS_S;
                        div_dividend  = a_val;
                        div_divisor   = DIVR_W'(1);
                    end
                end
            end
            S_DIV_C:
            begin
                if (div_done)
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEPS_S;
                    div_dividend  = {cb_dvd, 3'b000};
                    div_divisor   = DIVR_W'(c_new);
                end
            end
            S_DIV_S:
            begin
                if (div_done)
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEPS_M;
                    div_dividend  = {c_reg, {(DIVD_W-C_W){1'b0}}};
                    div_divisor   = DIVR_W'(m_reg);
                end
            end
            default:
            begin
                div_ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_bytes_next = rem_bytes_reg;
        bytes_next     = bytes_reg;
        c_next         = c_reg;
        m_next         = m_reg;
        cb_next        = cb_reg;
        per_lo_next    = per_lo_reg;
        per_hi_next    = per_hi_reg;
        mid_next       = mid_reg;
        sz_lo_next     = sz_lo_reg;
        sz_hi_next     = sz_hi_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bytes_next     = bytes_cl;
                    rem_bytes_next = bytes_cl;
                    idx_next       = '0;
                    c_next         = C_W'(1);
                    m_next         = M_W'(1);
                    if (bytes_in == '0)
                    begin
                        // flagged single group of zero bytes
                        err_next   = 1'b1;
                        mid_next   = '0;
                        sz_lo_next = '0;
                        sz_hi_next = '0;
                        state_next = S_EMIT;
                    end
                    else if (cfg.enable)
                    begin
                        state_next = S_DIV_C;
                    end
                    else
                    begin
                        state_next = S_DIV_S;
                    end
                end
            end
            S_DIV_C:
            begin
                if (div_done)
                begin
                    c_next     = c_new;
                    m_next     = ({{(C_W-M_W){1'b0}}, cfg.max_groups} < c_new) ?
                                 cfg.max_groups : c_new[M_W-1:0];
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                if (div_done)
                begin
                    cb_next    = div_quo[TB_W-1:0];
                    state_next = S_DIV_M;
                end
            end
            S_DIV_M:
            begin
                if (div_done)
                begin
                    per_lo_next = div_quo[C_W-1:0];
                    mid_next    = div_rem[M_W-1:0];
                    per_hi_next = div_quo[C_W-1:0] +
                                  C_W'(div_rem[M_W-1:0] != '0);
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                sz_lo_next = prod_lo[SZ_W-1:0];
                sz_hi_next = prod_hi[SZ_W-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {c_reg, m_reg, grp, idx_reg};
                    out_last_next  = grp_last;
                    out_err_next   = err_reg;
                    rem_bytes_next = rem_bytes_reg - grp;
                    if (grp_last)
                    begin
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_bytes_reg <= rem_bytes_next;
        bytes_reg     <= bytes_next;
        c_reg         <= c_next;
        m_reg         <= m_next;
        cb_reg        <= cb_next;
        per_lo_reg    <= per_lo_next;
        per_hi_reg    <= per_hi_next;
        mid_reg       <= mid_next;
        sz_lo_reg     <= sz_lo_next;
        sz_hi_reg     <= sz_hi_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

// ----- rtl/cbgs_checker.sv -----
module cbgs_checker
    import cbgs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                 $stable(m_tlast) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // no new block while groups of the current one are still pending
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while groups still pending");

    // last marks the final group index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (({1'b0, m_tdata[2:0]} + 4'd1) == m_tdata[23:20])) &&
                     (m_tdata[23:20] != 4'd0))
        else $error("last flag does not match group index and count");

    // a zero-size block gives one empty flagged group
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[19:3] == 17'd0) &&
                                (m_tdata[31:24] == 8'd1))
        else $error("length error beat malformed");

endmodule

bind code_block_group_segmenter cbgs_checker u_cbgs_checker (.*);

// ----- verif/tb_code_block_group_segmenter.sv -----
module tb_code_block_group_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    import cbgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 50;
    localparam int CALM_ITEMS     = 40;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [TB_W-1:0]  nbytes;
        logic [M_W-1:0]   groups;
        logic [C_W-1:0]   blocks;
        logic             err;
        logic             last;
    } grp_beat_t;

    typedef struct packed {
        logic              en;
        logic [M_W-1:0]    mg;
        logic [TB_W-1:0]   nbytes;
        logic [RATE_W-1:0] rate;
        logic              typed;
        grp_beat_t         beat;
    } tb_row_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [M_W-1:0]        cfg_data;

    // shadow of the block's registers
    logic                  cbg_on;
    logic [M_W-1:0]        group_cap;
    logic [M_W-1:0]        mg_written;

    grp_beat_t             group_beats_due[$];
    tb_row_t               dir_rows[$];
    grp_beat_t             seen_beat;
    grp_beat_t             due_beat;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    int                    hold_left = 0;
    bit                    calm = 0;

    code_block_group_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic grp_beat_t mk_beat(input int unsigned idx, input int unsigned nb,
                                          input int unsigned groups,
                                          input int unsigned blocks,
                                          input int unsigned err, input int unsigned last);
        grp_beat_t b;
        b.idx    = idx[IDX_W-1:0];
        b.nbytes = nb[TB_W-1:0];
        b.groups = groups[M_W-1:0];
        b.blocks = blocks[C_W-1:0];
        b.err    = err[0];
        b.last   = last[0];
        return b;
    endfunction

    // Append one beat to the expected list.
    function automatic void queue_due(input grp_beat_t b);
        group_beats_due.insert(group_beats_due.size(), b);
    endfunction

    // Queue the group beats one transport block produces under the current registers.
    function automatic void split_into_groups(input logic [TB_W-1:0] raw,
                                              input logic [RATE_W-1:0] rate);
        int unsigned nb, a, kcb, c, m, cbs, mid, per_lo, per_hi;
        int unsigned sz_hi, sz_lo, left, share, g, i;
        if (raw == '0)
        begin
            queue_due(mk_beat(0, 0, 1, 1, 1, 1));
        end
        else
        begin
            nb = 32'((raw > MAX_TB_BYTES) ? MAX_TB_BYTES : raw);
            a  = nb * 8;
            if (!cbg_on)
            begin
                c = 1;
                m = 1;
            end
            else
            begin
                kcb = 32'((a < A_SMALL_LIMIT || (a <= A_MID_LIMIT && rate <= RATE_MID) ||
                           rate <= RATE_LOW) ? KCB_SMALL : KCB_LARGE);
                c = (a + kcb - 1) / kcb;
                m = (group_cap < c) ? 32'(group_cap) : c;
                if (m == 0)
                    m = 1;
            end
            cbs    = (nb + c - 1) / c;
            mid    = c % m;
            per_lo = c / m;
            per_hi = per_lo + ((mid != 0) ? 1 : 0);
            sz_hi  = per_hi * cbs;
            sz_lo  = per_lo * cbs;
            left   = nb;
            for (i = 0; i < m; i++)
            begin
                share = (i < mid) ? sz_hi : sz_lo;
                g     = (left >= share) ? share : left;
                left  = left - g;
                queue_due(mk_beat(i, g, m, (c > 255) ? 255 : c, 0,
                                  (i + 1 == m) ? 1 : 0));
            end
        end
    endfunction

    task automatic add_row(input int unsigned en, input int unsigned mg,
                           input int unsigned nb, input int unsigned rate,
                           input int unsigned typed, input grp_beat_t beat);
        tb_row_t r;
        r.en     = en[0];
        r.mg     = mg[M_W-1:0];
        r.nbytes = nb[TB_W-1:0];
        r.rate   = rate[RATE_W-1:0];
        r.typed  = typed[0];
        r.beat   = beat;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic write_reg(input logic idx, input logic [M_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CBG_ENABLE)
            cbg_on = val[0];
        else if ((val == 2 || val == 4 || val == 6 || val == 8) && val <= MAX_GROUPS)
            group_cap = val;
    endtask

    // Drop valid and hold until every group beat has left the block.
    task automatic settle_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (group_beats_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Entered just after a rising edge; returns at the edge that accepts the beat.
    task automatic send_beat(input logic [TB_W-1:0] nb, input logic [RATE_W-1:0] rate,
                             input bit typed, input grp_beat_t beat);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {{(IN_DATA_W - TB_W - RATE_W){1'b0}}, rate, nb};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
            queue_due(beat);
        else
            split_into_groups(nb, rate);
    endtask

    task automatic pick_item(output logic [TB_W-1:0] nb, output logic [RATE_W-1:0] rate);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            nb = '0;
        else if (sel < 8)
            nb = TB_W'($urandom_range(65537, 131071));
        else if (sel < 14)
            nb = TB_W'($urandom_range(60000, 65536));
        else if (sel < 50)
            nb = TB_W'($urandom_range(1, 600));
        else
            nb = TB_W'($urandom_range(1, 65536));
        sel = $urandom_range(0, 99);
        if (sel < 15)
            rate = RATE_W'($urandom_range(250, 262));
        else if (sel < 30)
            rate = RATE_W'($urandom_range(680, 692));
        else if (sel < 40)
            rate = RATE_W'($urandom_range(1025, 2047));
        else
            rate = RATE_W'($urandom_range(0, 1024));
    endtask

    task automatic flag_mismatch(input string what, input grp_beat_t want,
                                 input grp_beat_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected idx %0d bytes %0d groups %0d blocks %0d err %0d last %0d,",
                     $realtime, what, want.idx, want.nbytes, want.groups, want.blocks,
                     want.err, want.last,
                     " got idx %0d bytes %0d groups %0d blocks %0d err %0d last %0d",
                     got.idx, got.nbytes, got.groups, got.blocks, got.err, got.last);
    endtask

    // Receiver: stall in short random bursts until the calm stretch.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && hold_left == 0 && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 6);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_beat.idx    = m_tdata[2:0];
            seen_beat.nbytes = m_tdata[19:3];
            seen_beat.groups = m_tdata[23:20];
            seen_beat.blocks = m_tdata[31:24];
            seen_beat.err    = m_tuser;
            seen_beat.last   = m_tlast;
            if (group_beats_due.size() == 0)
            begin
                flag_mismatch("unexpected beat", '0, seen_beat);
            end
            else
            begin
                due_beat = group_beats_due.pop_front();
                if (seen_beat.idx !== due_beat.idx || seen_beat.nbytes !== due_beat.nbytes ||
                    seen_beat.groups !== due_beat.groups ||
                    seen_beat.blocks !== due_beat.blocks ||
                    seen_beat.err !== due_beat.err || seen_beat.last !== due_beat.last)
                    flag_mismatch("group beat mismatch", due_beat, seen_beat);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [TB_W-1:0]   nb;
        logic [RATE_W-1:0] rate;
        logic              en;
        logic [M_W-1:0]    mg;
        tb_row_t           row;
        int                ph;
        int                k;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_CBG_ENABLE;
        cfg_data   = '0;
        cbg_on     = 1'b0;
        group_cap  = MAX_GROUPS;
        mg_written = MAX_GROUPS;

        // registers at reset value: zero size, extremes and oversize; then groups enabled: zero size and one byte
        add_row(0, 8, 0, 0, 1, mk_beat(0, 0, 1, 1, 1, 1));
        add_row(0, 8, 1, 0, 1, mk_beat(0, 1, 1, 1, 0, 1));
        add_row(0, 8, 65536, 1024, 1, mk_beat(0, 65536, 1, 1, 0, 1));
        add_row(0, 8, 131071, 2047, 1, mk_beat(0, 65536, 1, 1, 0, 1));
        add_row(0, 8, 40000, 300, 0, '0);
        add_row(1, 8, 0, 1024, 1, mk_beat(0, 0, 1, 1, 1, 1));
        add_row(1, 8, 1, 0, 1, mk_beat(0, 1, 1, 1, 0, 1));
        // block size thresholds on bit count and rate, then large blocks and each legal group limit
        add_row(1, 8, 36, 1024, 0, '0);
        add_row(1, 8, 37, 1024, 0, '0);
        add_row(1, 8, 478, 686, 0, '0);
        add_row(1, 8, 478, 687, 0, '0);
        add_row(1, 8, 481, 686, 0, '0);
        add_row(1, 8, 481, 256, 0, '0);
        add_row(1, 8, 481, 257, 0, '0);
        add_row(1, 8, 65536, 1024, 0, '0);
        add_row(1, 8, 65536, 0, 0, '0);
        add_row(1, 8, 131071, 2047, 0, '0);
        add_row(1, 2, 65536, 300, 0, '0);
        add_row(1, 4, 5000, 700, 0, '0);
        add_row(1, 6, 20000, 100, 0, '0);
        // rejected group limits keep the last legal one, then two legal ones
        add_row(1, 3, 20000, 100, 0, '0);
        add_row(1, 0, 9000, 900, 0, '0);
        add_row(1, 15, 30000, 2047, 0, '0);
        add_row(1, 8, 2000, 700, 0, '0);
        add_row(0, 2, 70000, 0, 0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.en != cbg_on || row.mg != mg_written)
            begin
                settle_outputs();
                if (row.en != cbg_on)
                    write_reg(REG_CBG_ENABLE, M_W'(row.en));
                if (row.mg != mg_written)
                begin
                    write_reg(REG_MAX_GROUPS, row.mg);
                    mg_written = row.mg;
                end
            end
            send_beat(row.nbytes, row.rate, row.typed, row.beat);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            settle_outputs();
            case (ph)
                0:
                begin
                    en = 1'b0;
                    mg = 4'd8;
                end
                1:
                begin
                    en = 1'b1;
                    mg = 4'd2;
                end
                2:
                begin
                    en = 1'b1;
                    mg = 4'd8;
                end
                3:
                begin
                    en = 1'b1;
                    mg = 4'd4;
                end
                4:
                begin
                    en = 1'b1;
                    mg = 4'd6;
                end
                default:
                begin
                    en = 1'($urandom_range(0, 1));
                    mg = M_W'($urandom_range(0, 15));
                end
            endcase
            write_reg(REG_CBG_ENABLE, M_W'(en));
            write_reg(REG_MAX_GROUPS, mg);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 5 && k >= PHASE_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                // hold the sender until the block has fully drained
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    settle_outputs();
                pick_item(nb, rate);
                send_beat(nb, rate, 1'b0, '0);
            end
        end

        settle_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && group_beats_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cbgs_pkg.sv
rtl/cbgs_cfg.sv
rtl/cbgs_div.sv
rtl/code_block_group_segmenter.sv
rtl/cbgs_checker.sv
verif/tb_code_block_group_segmenter.sv
